// ===== hw/rtl/i2cfb_pkg.sv =====
// Shared types and constants for the I2C slave FIFO bridge.
// No dependencies; used by the ring and the top level.
package i2cfb_pkg;

	// event codes on req_type
	localparam logic [2:0] REQ_ADDR    = 3'd0;
	localparam logic [2:0] REQ_DATA    = 3'd1;
	localparam logic [2:0] REQ_ERR     = 3'd2;
	localparam logic [2:0] REQ_TX_PUSH = 3'd3;
	localparam logic [2:0] REQ_RX_POP  = 3'd4;
	localparam logic [2:0] REQ_CLEAR   = 3'd5;

	// fill counts are carried wide enough for any legal depth (up to 256)
	localparam int unsigned FILL_W = 9;

	localparam logic [7:0] EMPTY_BYTE = 8'hFF;

	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} ring_cmd_t;

endpackage

// ===== hw/rtl/i2cfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cfb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/i2cfb_ring.sv =====
// Byte ring: read/write pointers around one i2cfb_ram, plus fill count.
// Depends on i2cfb_pkg and i2cfb_ram.
module i2cfb_ring #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2cfb_pkg::ring_cmd_t          cmd,
	input  logic [7:0]                    wdata,
	output logic [7:0]                    rdata,
	output logic                          empty,
	output logic [i2cfb_pkg::FILL_W-1:0]  fill
);

	localparam int unsigned PW = $clog2(DEPTH);

	logic [PW-1:0]                  wr_ptr_q, rd_ptr_q;
	logic [PW-1:0]                  wr_next, rd_next;
	logic [i2cfb_pkg::FILL_W-1:0]   diff;

	assign wr_next = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (cmd.clr) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= wr_next;
			end
			if (cmd.pop) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	// full ring wraps silently: a push onto a full ring leaves it reading empty
	assign empty = (wr_ptr_q == rd_ptr_q);

	assign diff = i2cfb_pkg::FILL_W'(wr_ptr_q) + i2cfb_pkg::FILL_W'(DEPTH)
		- i2cfb_pkg::FILL_W'(rd_ptr_q);
	assign fill = (diff >= i2cfb_pkg::FILL_W'(DEPTH)) ? diff - i2cfb_pkg::FILL_W'(DEPTH) : diff;

	i2cfb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wr_ptr_q),
		.wdata (wdata),
		.re    (cmd.pop),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

endmodule

// ===== hw/rtl/i2c_slave_fifo_bridge.sv =====
// I2C slave FIFO bridge: bus/local events against a transmit and a receive ring.
// Each accepted beat passes through s1 (which holds the RAM read), then the output register.
// Throughput: up to one beat per cycle while out_ready is high; set by the s1/output register pair.
// Reset (arst_n low, async): pointers, read mode and the s1/out valid flags clear;
// send_valid is not reset; ring RAM contents are not cleared and need no clearing pass.
// Depends on i2cfb_pkg and i2cfb_ring.
module i2c_slave_fifo_bridge #(
	parameter int unsigned RING_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] req_type,
	input  logic       master_reads,
	input  logic       clock_held,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       send_valid,
	output logic [7:0] send_byte,
	output logic       release_clock,
	output logic       errors_cleared,
	output logic [7:0] local_byte,
	output logic [4:0] tx_fill,
	output logic [4:0] rx_fill
);

	i2cfb_pkg::ring_cmd_t            tx_cmd, rx_cmd;
	logic [7:0]                      tx_rdata, rx_rdata;
	logic                            tx_empty, rx_empty;
	logic [i2cfb_pkg::FILL_W-1:0]    tx_fill_w, rx_fill_w;

	logic in_fire, adv;
	logic read_mode_q, read_mode_d;

	// decoded result of the accepted beat
	logic       sv_d, send_ram_d, rel_d, clr_d, local_ram_d;
	logic [7:0] send_byte_d, local_byte_d;

	logic       s1_valid_q;
	logic       sv_s1, send_ram_s1, rel_s1, clr_s1, local_ram_s1;
	logic [7:0] send_byte_s1, local_byte_s1;

	logic       out_valid_q;
	logic       send_valid_q, release_q, cleared_q;
	logic [7:0] send_byte_q, local_byte_q;
	logic [4:0] tx_fill_q, rx_fill_q;

	assign adv      = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || adv;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		read_mode_d  = read_mode_q;
		sv_d         = 1'b0;
		send_ram_d   = 1'b0;
		send_byte_d  = 8'd0;
		rel_d        = 1'b0;
		clr_d        = 1'b0;
		local_ram_d  = 1'b0;
		local_byte_d = 8'd0;
		tx_cmd       = '0;
		rx_cmd       = '0;
		case (req_type)
			i2cfb_pkg::REQ_ADDR: begin
				if (!master_reads) begin
					read_mode_d = 1'b0;
					rel_d       = 1'b1;
				end else begin
					read_mode_d = 1'b1;
					if (clock_held) begin
						sv_d        = 1'b1;
						send_byte_d = tx_fill_w[7:0];
						rel_d       = 1'b1;
					end
				end
			end
			i2cfb_pkg::REQ_DATA: begin
				if (!read_mode_q) begin
					rx_cmd.push = 1'b1;
				end else if (clock_held) begin
					sv_d  = 1'b1;
					rel_d = 1'b1;
					if (tx_empty) begin
						send_byte_d = i2cfb_pkg::EMPTY_BYTE;
					end else begin
						tx_cmd.pop = 1'b1;
						send_ram_d = 1'b1;
					end
				end
			end
			i2cfb_pkg::REQ_ERR: begin
				clr_d = 1'b1;
			end
			i2cfb_pkg::REQ_TX_PUSH: begin
				tx_cmd.push = 1'b1;
			end
			i2cfb_pkg::REQ_RX_POP: begin
				if (rx_empty) begin
					local_byte_d = i2cfb_pkg::EMPTY_BYTE;
				end else begin
					rx_cmd.pop  = 1'b1;
					local_ram_d = 1'b1;
				end
			end
			i2cfb_pkg::REQ_CLEAR: begin
				tx_cmd.clr = 1'b1;
				rx_cmd.clr = 1'b1;
			end
			default: begin
			end
		endcase
		if (!in_fire) begin
			read_mode_d = read_mode_q;
			tx_cmd      = '0;
			rx_cmd      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_mode_q <= 1'b0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			read_mode_q <= read_mode_d;
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sv_s1         <= sv_d;
			send_ram_s1   <= send_ram_d;
			send_byte_s1  <= send_byte_d;
			rel_s1        <= rel_d;
			clr_s1        <= clr_d;
			local_ram_s1  <= local_ram_d;
			local_byte_s1 <= local_byte_d;
		end
	end

	// RAM read data lands in the cycle after the pop; pointers already reflect the beat
	always_ff @(posedge clk) begin
		if (adv) begin
			send_valid_q <= sv_s1;
			send_byte_q  <= send_ram_s1 ? tx_rdata : send_byte_s1;
			release_q    <= rel_s1;
			cleared_q    <= clr_s1;
			local_byte_q <= local_ram_s1 ? rx_rdata : local_byte_s1;
			tx_fill_q    <= tx_fill_w[4:0];
			rx_fill_q    <= rx_fill_w[4:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign send_valid     = send_valid_q;
	assign send_byte      = send_byte_q;
	assign release_clock  = release_q;
	assign errors_cleared = cleared_q;
	assign local_byte     = local_byte_q;
	assign tx_fill        = tx_fill_q;
	assign rx_fill        = rx_fill_q;

	i2cfb_ring #(
		.DEPTH (RING_DEPTH)
	) u_tx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tx_cmd),
		.wdata  (data_byte),
		.rdata  (tx_rdata),
		.empty  (tx_empty),
		.fill   (tx_fill_w)
	);

	i2cfb_ring #(
		.DEPTH (RING_DEPTH)
	) u_rx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rx_cmd),
		.wdata  (data_byte),
		.rdata  (rx_rdata),
		.empty  (rx_empty),
		.fill   (rx_fill_w)
	);

endmodule

// ===== hw/rtl/i2cfb_checker.sv =====
// Port-level checks for i2c_slave_fifo_bridge, attached by bind.
// Depends only on the top level's ports.
module i2cfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [2:0] req_type,
	input logic       master_reads,
	input logic       clock_held,
	input logic [7:0] data_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       send_valid,
	input logic [7:0] send_byte,
	input logic       release_clock,
	input logic       errors_cleared,
	input logic [7:0] local_byte,
	input logic [4:0] tx_fill,
	input logic [4:0] rx_fill
);

	// a waiting request beat holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(req_type) && $stable(master_reads)
			&& $stable(clock_held) && $stable(data_byte))
		else $error("request beat changed while stalled");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(send_byte)
			&& $stable(local_byte) && $stable(tx_fill) && $stable(rx_fill))
		else $error("result beat changed while stalled");

	// any byte for the master comes with a clock release
	a_send_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_valid |-> release_clock)
		else $error("send without clock release");

	// error clearing is a result of its own
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && errors_cleared |-> !send_valid && !release_clock && local_byte == 8'd0)
		else $error("error clear mixed with other results");

	// bus reply and local pop never share a beat
	a_send_local: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_valid |-> local_byte == 8'd0)
		else $error("send beat carries a local byte");

endmodule

bind i2c_slave_fifo_bridge i2cfb_checker u_i2cfb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.req_type       (req_type),
	.master_reads   (master_reads),
	.clock_held     (clock_held),
	.data_byte      (data_byte),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.send_valid     (send_valid),
	.send_byte      (send_byte),
	.release_clock  (release_clock),
	.errors_cleared (errors_cleared),
	.local_byte     (local_byte),
	.tx_fill        (tx_fill),
	.rx_fill        (rx_fill)
);
